// File: design/llsa_pkg.sv
// shared types and constants for the least loaded server assignment block
// used by least_loaded_server_assign_top
`default_nettype none

package llsa_pkg;

	localparam int unsigned LOAD_W   = 32;
	localparam int unsigned SRV_W    = 7;
	localparam int unsigned STIME_W  = 16;
	localparam int unsigned ODATA_W  = 48;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [LOAD_W-1:0] LOAD_TOP = '1;

	// command codes carried in tuser
	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// register word index
	localparam logic REG_ACTIVE_SERVERS = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_FINISH
	} state_t;

	typedef logic [LOAD_W-1:0] load_t;
	typedef logic [SRV_W-1:0]  srv_num_t;

endpackage

`default_nettype wire

// File: design/llsa_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module llsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                                     clk,
	input  wire                                     we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                        wdata,
	input  wire                                     re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/least_loaded_server_assign_top.sv
// least loaded server assignment: loads in one ram, scanned once per job
// a job reads the loads of the n servers in use (n = servers in use) one entry per cycle in a
//   read scan, then writes back the updated load; a clear zeroes all MAX_SERVERS entries
// throughput: one item in flight;
//   the next input transfer is taken while a result waits
// reset: asynchronous, then a sweep of all MAX_SERVERS entries zeroes the ram, no input taken
`default_nettype none

module least_loaded_server_assign_top #(
	parameter int MAX_SERVERS = 64
) (
	input  wire                            clk,
	input  wire                            arst_n,
	// slave side
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	input  wire  [llsa_pkg::STIME_W-1:0]   s_axis_tdata,  // service_time[15:0]
	input  wire  [0:0]                     s_axis_tuser,  // cmd[0]
	// master side
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	output logic [llsa_pkg::ODATA_W-1:0]   m_axis_tdata,  // assigned_server[6:0],
	                                                      // next_server[13:7],
	                                                      // next_load[45:14], zero[47:46]
	// configuration
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [llsa_pkg::PADDR_W-1:0]   paddr,
	input  wire  [llsa_pkg::PDATA_W-1:0]   pwdata,
	output logic [llsa_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	import llsa_pkg::*;

	localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CW = $clog2(MAX_SERVERS + 1) > 0 ? $clog2(MAX_SERVERS + 1) : 1;
	localparam logic [CW-1:0] LAST_ENTRY = CW'(MAX_SERVERS - 1);

	state_t state_q, state_d;

	logic [SRV_W-1:0]   active_q;
	logic [CW-1:0]      n_srv;
	logic [CW-1:0]      clr_q;
	logic               clr_item_q;
	logic [CW-1:0]      rd_cnt_q;
	logic [STIME_W-1:0] st_q;

	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               rd_last;

	load_t              b1_load_q, b2_load_q;
	logic [AW-1:0]      b1_idx_q, b2_idx_q;
	logic               b2_ok_q;

	srv_num_t           res_asg_q, res_nxt_q;
	load_t              res_load_q;
	logic               m_valid_q;
	logic [ODATA_W-1:0] m_data_q;

	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	load_t              ram_wdata, ram_rdata;
	logic [LOAD_W:0]    sum;
	load_t              new_load;
	logic               pick_b1;
	logic               s_fire, out_load, cfg_wr;

	llsa_ram #(
		.WIDTH(LOAD_W),
		.DEPTH(MAX_SERVERS)
	) u_load_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ACTIVE_SERVERS) ? PDATA_W'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= SRV_W'(1);
		end else if (cfg_wr && paddr[2] == REG_ACTIVE_SERVERS) begin
			active_q <= pwdata[SRV_W-1:0];
		end
	end

	// servers in use, clamped to 1..MAX_SERVERS
	always_comb begin
		if (active_q == '0) begin
			n_srv = CW'(1);
		end else if (32'(active_q) > 32'(MAX_SERVERS)) begin
			n_srv = CW'(MAX_SERVERS);
		end else begin
			n_srv = CW'(active_q);
		end
	end

	assign s_fire  = s_axis_tvalid && s_axis_tready;
	assign rd_last = rd_vld_s1 && (CW'(rd_idx_s1) == n_srv - CW'(1));

	// saturating update and choice of the next server
	assign sum      = {1'b0, b1_load_q} + (LOAD_W + 1)'(st_q);
	assign new_load = sum[LOAD_W] ? LOAD_TOP : sum[LOAD_W-1:0];
	assign pick_b1  = !b2_ok_q || (new_load < b2_load_q) ||
		((new_load == b2_load_q) && (b1_idx_q < b2_idx_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ENTRY) begin
					state_d = clr_item_q ? ST_FINISH : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_fire) begin
					state_d = (s_axis_tuser[0] == CMD_CLEAR) ? ST_CLEAR : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the state machine
	always_comb begin
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = b1_idx_q;
		ram_wdata     = new_load;
		ram_re        = 1'b0;
		ram_raddr     = rd_cnt_q[AW-1:0];
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[AW-1:0];
				ram_wdata = '0;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_SCAN: begin
				ram_re = (rd_cnt_q < n_srv);
			end
			ST_UPDATE: begin
				ram_we = 1'b1;
			end
			ST_FINISH: begin
				out_load = !m_valid_q || m_axis_tready;
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			clr_item_q <= 1'b0;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			b2_ok_q    <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= ram_re;
			if (s_fire) begin
				clr_q      <= '0;
				clr_item_q <= (s_axis_tuser[0] == CMD_CLEAR);
				rd_cnt_q   <= '0;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (ram_re) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			if (state_q == ST_SCAN && rd_vld_s1) begin
				if (rd_idx_s1 == '0) begin
					b2_ok_q <= 1'b0;
				end else if (ram_rdata < b1_load_q || !b2_ok_q ||
					ram_rdata < b2_load_q) begin
					b2_ok_q <= 1'b1;
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			st_q <= s_axis_tdata;
		end
		rd_idx_s1 <= ram_raddr;
		if (state_q == ST_SCAN && rd_vld_s1) begin
			if (rd_idx_s1 == '0) begin
				b1_load_q <= ram_rdata;
				b1_idx_q  <= rd_idx_s1;
			end else if (ram_rdata < b1_load_q) begin
				b2_load_q <= b1_load_q;
				b2_idx_q  <= b1_idx_q;
				b1_load_q <= ram_rdata;
				b1_idx_q  <= rd_idx_s1;
			end else if (!b2_ok_q || ram_rdata < b2_load_q) begin
				b2_load_q <= ram_rdata;
				b2_idx_q  <= rd_idx_s1;
			end
		end
		if (state_q == ST_UPDATE) begin
			res_asg_q <= SRV_W'(32'(b1_idx_q) + 32'd1);
			if (pick_b1) begin
				res_nxt_q  <= SRV_W'(32'(b1_idx_q) + 32'd1);
				res_load_q <= new_load;
			end else begin
				res_nxt_q  <= SRV_W'(32'(b2_idx_q) + 32'd1);
				res_load_q <= b2_load_q;
			end
		end
		if (state_q == ST_CLEAR && clr_q == LAST_ENTRY) begin
			res_asg_q  <= '0;
			res_nxt_q  <= SRV_W'(1);
			res_load_q <= '0;
		end
		if (out_load) begin
			m_data_q <= {{(ODATA_W - LOAD_W - 2 * SRV_W){1'b0}},
				res_load_q, res_nxt_q, res_asg_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// checks
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("load ram written and read in one cycle");

	a_fire_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> (state_q == ST_SCAN || state_q == ST_CLEAR))
		else $error("accepted transfer did not start a scan or clear");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE |-> CW'(b1_idx_q) < n_srv)
		else $error("chosen server outside the servers in use");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(state_q) == ST_FINISH)
		else $error("result raised outside the finish step");

endmodule

`default_nettype wire
